FILE: hdl/skhc_pkg.sv
// ----------------------------------------------------------------------------
// skhc_pkg
// Shared constants and types for the sorted key hit counter.
// ----------------------------------------------------------------------------
package skhc_pkg;

  // Default table geometry.
  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_COUNT_WIDTH = 32;

  // Fixed widths of the transaction fields.
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SLOT_W = 8;
  localparam int unsigned HIT_W  = 32;

  // One result transaction as it leaves the controller.
  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [HIT_W-1:0]  hit_count;
    logic              is_new;
    logic              table_full;
  } res_t;

  // Network byte order to host byte order.
  function automatic logic [KEY_W-1:0] swap_bytes(input logic [KEY_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: hdl/skhc_ram.sv
// ----------------------------------------------------------------------------
// skhc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module skhc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/skhc_ctrl.sv
// ----------------------------------------------------------------------------
// skhc_ctrl
// Search, shift and update sequencer around the entry RAM.
// ----------------------------------------------------------------------------
module skhc_ctrl
  import skhc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned EW = KEY_W + COUNT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  // Input transaction.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] addr_net_order,
  // Result toward the output register.
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  // Entry RAM.
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [EW-1:0]    wr_data,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  logic [EW-1:0]    rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_MISS,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t               state;
  logic [KEY_W-1:0]     key;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi;
  logic [AW-1:0]        mid;
  logic [AW-1:0]        sh;
  logic [CW-1:0]        pos;
  logic [COUNT_WIDTH-1:0] cnt;
  logic                 new_flag;
  logic                 full_flag;
  logic [CW-1:0]        entry_count;

  logic [KEY_W-1:0]       rd_key;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [COUNT_WIDTH-1:0] rd_cnt_inc;
  logic                   key_hit;
  logic [CW-1:0]          lo_next;
  logic [CW-1:0]          hi_next;
  logic [CW-1:0]          mid_next;
  logic                   in_fire;

  assign rd_key  = rd_data[EW-1:COUNT_WIDTH];
  assign rd_cnt  = rd_data[COUNT_WIDTH-1:0];
  assign key_hit = (key == rd_key);
  assign in_fire = in_valid && !in_stall;

  // Saturating increment of the stored count.
  assign rd_cnt_inc = (rd_cnt == {COUNT_WIDTH{1'b1}}) ? rd_cnt : rd_cnt + 1'b1;

  // Next search bounds after comparing against the entry at mid.
  always_comb begin
    if (key < rd_key) begin
      lo_next = lo;
      hi_next = CW'(mid);
    end else begin
      lo_next = CW'(mid) + 1'b1;
      hi_next = hi;
    end
    mid_next = lo_next + ((hi_next - lo_next) >> 1);
  end

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_FINISH);
  assign res.slot_index = SLOT_W'(pos);
  assign res.hit_count  = HIT_W'(cnt);
  assign res.is_new     = new_flag;
  assign res.table_full = full_flag;

  // RAM port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_en   = in_fire;
        rd_addr = AW'(entry_count >> 1);
      end
      S_CMP: begin
        rd_en   = !key_hit && (lo_next < hi_next);
        rd_addr = mid_next[AW-1:0];
      end
      S_MISS: begin
        rd_en   = 1'b1;
        rd_addr = AW'(entry_count - 1'b1);
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(CW'(sh) + 1'b1);
        rd_en   = (CW'(sh) != pos);
        rd_addr = sh - 1'b1;
      end
      S_FINISH: begin
        wr_en   = res_ready && !full_flag;
        wr_addr = pos[AW-1:0];
        wr_data = {key, cnt};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            key       <= swap_bytes(addr_net_order);
            lo        <= '0;
            hi        <= entry_count;
            mid       <= AW'(entry_count >> 1);
            pos       <= '0;
            new_flag  <= 1'b0;
            full_flag <= 1'b0;
            state     <= (entry_count == '0) ? S_MISS : S_CMP;
          end
        end
        S_CMP: begin
          if (key_hit) begin
            pos   <= CW'(mid);
            cnt   <= rd_cnt_inc;
            state <= S_FINISH;
          end else if (lo_next < hi_next) begin
            lo  <= lo_next;
            hi  <= hi_next;
            mid <= mid_next[AW-1:0];
          end else begin
            pos   <= lo_next;
            state <= S_MISS;
          end
        end
        S_MISS: begin
          if (entry_count == CW'(TABLE_DEPTH)) begin
            // Absent and no room: drop it and report a full table.
            pos       <= '0;
            cnt       <= '0;
            full_flag <= 1'b1;
            state     <= S_FINISH;
          end else if (entry_count > pos) begin
            sh    <= AW'(entry_count - 1'b1);
            state <= S_SHIFT;
          end else begin
            cnt      <= COUNT_WIDTH'(1);
            new_flag <= 1'b1;
            state    <= S_FINISH;
          end
        end
        S_SHIFT: begin
          if (CW'(sh) == pos) begin
            cnt      <= COUNT_WIDTH'(1);
            new_flag <= 1'b1;
            state    <= S_FINISH;
          end else begin
            sh <= sh - 1'b1;
          end
        end
        S_FINISH: begin
          if (res_ready) begin
            if (new_flag) begin
              entry_count <= entry_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/sorted_key_hit_counter.sv
// ----------------------------------------------------------------------------
// sorted_key_hit_counter
// Per-address hit counter over a table kept sorted by address.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_stall  | addr_net_order
//   output  | out_valid / out_stall| slot_index, hit_count, is_new, table_full
//
// A known address is found in k binary search steps (at most
// ceil(log2(n + 1)) for n stored entries, 9 for a full table of 256). The
// search does one compare per cycle against the single read port of the
// entry RAM. A new address also moves every entry above its insertion point
// up by one, and the shift copies one entry per RAM read/write cycle. A
// full-table drop moves nothing and is reported once the search is done.
// Reset (rst, synchronous) empties the table at once; there is no clearing
// pass. The output register lets the next transaction be taken while a
// result is still stalled; the controller only waits when it has a second
// result ready and the register is still occupied.
//
module sorted_key_hit_counter
  import skhc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KEY_W-1:0]  addr_net_order,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] slot_index,
  output logic [HIT_W-1:0]  hit_count,
  output logic              is_new,
  output logic              table_full
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW = KEY_W + COUNT_WIDTH;

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  // Each RAM word holds one entry: the address in host order above its count.
  skhc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  skhc_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .addr_net_order (addr_net_order),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  // The output register is free when empty or when its transaction leaves now.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // Payload holds while stalled; it needs no reset.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      slot_index <= res.slot_index;
      hit_count  <= res.hit_count;
      is_new     <= res.is_new;
      table_full <= res.table_full;
    end
  end

`ifndef NO_ASSERTIONS
  // A freshly inserted address always reports its first hit.
  a_new_first_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new |-> hit_count == HIT_W'(1))
    else $error("new entry does not report a count of one");

  // A dropped address reports no slot, no count and no insertion.
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !is_new && hit_count == '0 && slot_index == '0)
    else $error("full-table result carries entry data");

  // A result handed to a free output register shows up there next cycle.
  a_res_load: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> out_valid)
    else $error("result lost between controller and output register");

  // An accepted transaction keeps the input side busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the search started");
`endif

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted key hit counter.
// Fills the address table through a directed opening and random traffic, then
// keeps hitting and missing on the full table, under random input idle and
// output stall. Every result is checked against a local model of the table.
// ----------------------------------------------------------------------------
module testbench
  import skhc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Total number of address transactions that the stimulus aims for.
  localparam int ITEM_TARGET = 1050;
  // Minimum number of transactions sent once the table is full.
  localparam int FULL_MIN = 150;
  // Quiet cycles after the last result; covers the longest insert shift.
  localparam int DRAIN_CYCLES = DEF_TABLE_DEPTH + 64;

  // One row of the directed opening. When pinned is set, want holds the result
  // read straight off the behavior; otherwise the local model supplies it.
  typedef struct {
    logic [KEY_W-1:0] addr;
    bit               pinned;
    res_t             want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KEY_W-1:0]  addr_net_order = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SLOT_W-1:0] slot_index;
  logic [HIT_W-1:0]  hit_count;
  logic              is_new;
  logic              table_full;

  // Local copy of the table: host-order addresses in ascending order, with
  // their counts. Only the first live_entries slots are meaningful.
  logic [KEY_W-1:0]           sorted_keys [DEF_TABLE_DEPTH];
  logic [DEF_COUNT_WIDTH-1:0] hit_totals  [DEF_TABLE_DEPTH];
  int                         live_entries = 0;

  // Results predicted for accepted addresses, oldest first.
  res_t pending_tallies [$];

  int n_sent     = 0;
  int n_inserted = 0;
  int n_repeats  = 0;
  int n_dropped  = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int burst_left = 0;

  // Directed opening. The table starts empty, so the first rows have results
  // that can be worked out by hand: both extreme addresses, byte order checks
  // where only the top or the bottom byte is set, and inserts at the front,
  // middle and end of the table. The later rows are left to the model.
  plan_row_t opening [22] = '{
    '{32'h0000_0000, 1'b1, '{8'd0, 32'd1, 1'b1, 1'b0}},
    '{32'h0000_0000, 1'b1, '{8'd0, 32'd2, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, '{8'd1, 32'd1, 1'b1, 1'b0}},
    '{32'h0100_0000, 1'b1, '{8'd1, 32'd1, 1'b1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, '{8'd2, 32'd2, 1'b0, 1'b0}},
    '{32'h0000_0001, 1'b1, '{8'd2, 32'd1, 1'b1, 1'b0}},
    '{32'h8000_0000, 1'b1, '{8'd2, 32'd1, 1'b1, 1'b0}},
    '{32'h0000_0080, 1'b1, '{8'd4, 32'd1, 1'b1, 1'b0}},
    '{32'hFEFF_FFFF, 1'b1, '{8'd5, 32'd1, 1'b1, 1'b0}},
    '{32'h0000_0000, 1'b1, '{8'd0, 32'd3, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, '{8'd6, 32'd3, 1'b0, 1'b0}},
    '{32'h1234_5678, 1'b0, '0},
    '{32'h7856_3412, 1'b0, '0},
    '{32'hA5A5_A5A5, 1'b0, '0},
    '{32'h5A5A_5A5A, 1'b0, '0},
    '{32'h1234_5678, 1'b0, '0},
    '{32'h00FF_00FF, 1'b0, '0},
    '{32'hFF00_FF00, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'h0000_0080, 1'b0, '0},
    '{32'hDEAD_BEEF, 1'b0, '0},
    '{32'h0100_0000, 1'b0, '0}
  };

  sorted_key_hit_counter DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .addr_net_order (addr_net_order),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .slot_index     (slot_index),
    .hit_count      (hit_count),
    .is_new         (is_new),
    .table_full     (table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Converts between network and host byte order; the mapping is its own
  // inverse, so the same helper serves both directions.
  function automatic logic [KEY_W-1:0] flip_bytes(input logic [KEY_W-1:0] v);
    logic [KEY_W-1:0] r;
    int b;
    for (b = 0; b < KEY_W / 8; b++) begin
      r[8*b +: 8] = v[KEY_W - 8*(b + 1) +: 8];
    end
    return r;
  endfunction

  // Applies one address to the local table and returns the result it causes.
  // A binary search finds the address or its insertion point. A missing
  // address moves every later entry up by one and enters with a count of
  // zero, unless the table is full, in which case nothing changes and only
  // the full flag is reported. The count then steps up and holds at its top.
  function automatic res_t tally_address(input logic [KEY_W-1:0] net);
    logic [KEY_W-1:0] key;
    int   lo;
    int   hi;
    int   mid;
    int   i;
    bit   found;
    res_t r;
    key   = flip_bytes(net);
    lo    = 0;
    hi    = live_entries;
    found = 1'b0;
    r     = '0;
    while (lo < hi && !found) begin
      mid = lo + (hi - lo) / 2;
      if (key < sorted_keys[mid]) begin
        hi = mid;
      end else if (key > sorted_keys[mid]) begin
        lo = mid + 1;
      end else begin
        found = 1'b1;
        lo    = mid;
      end
    end
    if (!found) begin
      if (live_entries >= DEF_TABLE_DEPTH) begin
        r.table_full = 1'b1;
        n_dropped++;
        return r;
      end
      for (i = live_entries; i > lo; i--) begin
        sorted_keys[i] = sorted_keys[i-1];
        hit_totals[i]  = hit_totals[i-1];
      end
      sorted_keys[lo] = key;
      hit_totals[lo]  = '0;
      live_entries++;
      n_inserted++;
    end else begin
      n_repeats++;
    end
    if (hit_totals[lo] != '1) begin
      hit_totals[lo] = hit_totals[lo] + 1'b1;
    end
    r.slot_index = SLOT_W'(lo);
    r.hit_count  = hit_totals[lo][HIT_W-1:0];
    r.is_new     = !found;
    return r;
  endfunction

  // Idle cycles before the next address. Most gaps are short, a few are long,
  // and now and then a burst of back-to-back transactions goes through.
  function automatic int sender_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Network-order address of a stored entry, picked at random. Now and then
  // the first or the last entry is taken, so the search ends are hit often.
  function automatic logic [KEY_W-1:0] stored_address();
    int r;
    int idx;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      idx = 0;
    end else if (r == 1) begin
      idx = live_entries - 1;
    end else begin
      idx = $urandom_range(0, live_entries - 1);
    end
    return flip_bytes(sorted_keys[idx]);
  endfunction

  // Network-order address one above or one below a stored entry in host order.
  // Such neighbors make the search walk right up to an existing key.
  function automatic logic [KEY_W-1:0] neighbor_address();
    logic [KEY_W-1:0] k;
    k = sorted_keys[$urandom_range(0, live_entries - 1)];
    if ($urandom_range(0, 1) == 1) begin
      k = k + 1'b1;
    end else begin
      k = k - 1'b1;
    end
    return flip_bytes(k);
  endfunction

  // Sends one address transaction. The task is entered at a rising edge. The
  // valid is lowered only when an idle gap follows, so a valid that stays up
  // for the next transaction never gets two assignments in one time step.
  // Once the transaction is taken, the expected result is queued: either the
  // pinned one from the directed table or the model's own.
  task automatic feed_address(input logic [KEY_W-1:0] net, input bit pinned,
                              input res_t want);
    int   gap;
    res_t r;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    addr_net_order <= net;
    do @(posedge clk); while (in_stall);
    r = tally_address(net);
    pending_tallies.push_back(pinned ? want : r);
    n_sent++;
  endtask

  // Stimulus: reset, the directed opening, then random traffic in two parts.
  // The first part fills the table with fresh addresses mixed with repeats;
  // the second keeps counting stored addresses while missing ones are dropped
  // on the full table.
  initial begin : stimulus
    int r;
    int full_sent;
    int idx;
    logic [KEY_W-1:0] k;
    full_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (idx = 0; idx < $size(opening); idx++) begin
      feed_address(opening[idx].addr, opening[idx].pinned, opening[idx].want);
    end

    while (live_entries < DEF_TABLE_DEPTH) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        k = stored_address();
      end else if (r < 70) begin
        k = $urandom;
      end else if (r < 88) begin
        k = neighbor_address();
      end else if (r < 94) begin
        k = flip_bytes(KEY_W'($urandom_range(0, 255)));
      end else begin
        k = flip_bytes(~KEY_W'($urandom_range(0, 255)));
      end
      feed_address(k, 1'b0, '0);
    end

    while (n_sent < ITEM_TARGET || full_sent < FULL_MIN) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        k = stored_address();
      end else if (r < 75) begin
        k = neighbor_address();
      end else begin
        k = $urandom;
      end
      feed_address(k, 1'b0, '0);
      full_sent++;
    end
    in_valid <= 1'b0;

    // Let every expected result come out, then watch a while longer for any
    // result that should not be there.
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d addresses: %0d inserted, %0d counted again, %0d dropped on a full table.",
             n_sent, n_inserted, n_repeats, n_dropped);
    $display("Table held %0d of %0d entries; %0d results checked, %0d mismatches.",
             live_entries, DEF_TABLE_DEPTH, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: checks every accepted result transaction against the oldest
  // prediction and drives the stall in random runs. Short stalls are common,
  // long ones rare, and open runs give stretches with no back-pressure.
  initial begin : result_check
    int   stall_left;
    bit   stall_now;
    int   r;
    res_t exp;
    stall_left = 0;
    stall_now  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_tallies.size() == 0) begin
          $error("Result with no transaction waiting: slot %0d count %0d",
                 slot_index, hit_count);
          n_errors++;
        end else begin
          exp = pending_tallies.pop_front();
          n_checked++;
          if (slot_index !== exp.slot_index) begin
            $error("slot_index: expected %0d, got %0d", exp.slot_index, slot_index);
            n_errors++;
          end
          if (hit_count !== exp.hit_count) begin
            $error("hit_count: expected %0d, got %0d", exp.hit_count, hit_count);
            n_errors++;
          end
          if (is_new !== exp.is_new) begin
            $error("is_new: expected %0b, got %0b", exp.is_new, is_new);
            n_errors++;
          end
          if (table_full !== exp.table_full) begin
            $error("table_full: expected %0b, got %0b", exp.table_full, table_full);
            n_errors++;
          end
        end
      end
      if (stall_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          stall_now  = 1'b0;
          stall_left = $urandom_range(1, 30);
        end else if (r < 93) begin
          stall_now  = 1'b1;
          stall_left = $urandom_range(1, 3);
        end else begin
          stall_now  = 1'b1;
          stall_left = $urandom_range(15, 60);
        end
      end
      stall_left--;
      out_stall <= stall_now;
    end
  end

  // Hard stop. The slowest correct run, with every address shifting the whole
  // table and every gap and stall at its longest, stays well inside this.
  initial begin : watchdog
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
